// File: rtl/r2y_pkg.sv
`timescale 1ns / 1ps

package r2y_pkg;

  // Raster counter width; frame dimensions saturate at 2**MAX_DIM_BITS.
  localparam int MAX_DIM_BITS = 12;

  localparam int PIXEL_W    = 32;
  localparam int RGB_W      = 24;
  localparam int BYTE_W     = 8;
  localparam int CFG_DIM_W  = 13;
  localparam int STRIDE_W   = 15;
  localparam int OFF_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Width for comparing counters against clamped dimensions.
  localparam int CMP_W = (MAX_DIM_BITS + 1 > CFG_DIM_W) ? MAX_DIM_BITS + 1 : CFG_DIM_W;

  // Width for offset products before wrapping to OFF_W bits.
  localparam int PROD_W = MAX_DIM_BITS + STRIDE_W;
  localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 1;

  // Result packing: luma, luma offset, cb, cr, cb offset, cr offset.
  localparam int RES_BITS = 4 * BYTE_W + 3 * OFF_W - BYTE_W;
  localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CHROMA_LAYOUT = 3'd2,
    REG_LUMA_STRIDE   = 3'd3,
    REG_CB_STRIDE     = 3'd4,
    REG_CR_STRIDE     = 3'd5
  } reg_idx_t;

  typedef enum logic {
    LAYOUT_PLANAR = 1'b0,
    LAYOUT_NV12   = 1'b1
  } layout_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    layout_t              chroma_layout;
    logic [STRIDE_W-1:0]  luma_stride;
    logic [STRIDE_W-1:0]  cb_stride;
    logic [STRIDE_W-1:0]  cr_stride;
  } cfg_t;

  // One pixel sitting in the input register.
  typedef struct packed {
    logic                    valid;
    logic [RGB_W-1:0]        rgb;
    logic [MAX_DIM_BITS-1:0] row;
    logic [MAX_DIM_BITS-1:0] col;
    logic                    chroma_valid;
    logic                    frame_end;
  } scan_t;

endpackage

// File: rtl/r2y_cfg.sv
`timescale 1ns / 1ps

module r2y_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [r2y_pkg::CFG_DATA_W-1:0]   wr_data,
  output r2y_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= r2y_pkg::CFG_DIM_W'(640);
      cfg.frame_height  <= r2y_pkg::CFG_DIM_W'(480);
      cfg.chroma_layout <= r2y_pkg::LAYOUT_PLANAR;
      cfg.luma_stride   <= r2y_pkg::STRIDE_W'(640);
      cfg.cb_stride     <= r2y_pkg::STRIDE_W'(320);
      cfg.cr_stride     <= r2y_pkg::STRIDE_W'(320);
    end else if (wr_en) begin
      unique case (wr_index)
        r2y_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= wr_data[r2y_pkg::CFG_DIM_W-1:0];
        r2y_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= wr_data[r2y_pkg::CFG_DIM_W-1:0];
        r2y_pkg::REG_CHROMA_LAYOUT: cfg.chroma_layout <= r2y_pkg::layout_t'(wr_data[0]);
        r2y_pkg::REG_LUMA_STRIDE:   cfg.luma_stride   <= wr_data[r2y_pkg::STRIDE_W-1:0];
        r2y_pkg::REG_CB_STRIDE:     cfg.cb_stride     <= wr_data[r2y_pkg::STRIDE_W-1:0];
        r2y_pkg::REG_CR_STRIDE:     cfg.cr_stride     <= wr_data[r2y_pkg::STRIDE_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: rtl/r2y_scan.sv
`timescale 1ns / 1ps

module r2y_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  r2y_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  input  logic [r2y_pkg::PIXEL_W-1:0]      in_pixel,
  output logic                             in_ready,
  input  logic                             take,
  output r2y_pkg::scan_t                   stage
);

  localparam int CW = r2y_pkg::CMP_W;
  localparam logic [CW-1:0] DIM_TOP = CW'(1) << r2y_pkg::MAX_DIM_BITS;

  logic [r2y_pkg::MAX_DIM_BITS-1:0] col;
  logic [r2y_pkg::MAX_DIM_BITS-1:0] row;
  logic [CW-1:0] width_ext;
  logic [CW-1:0] height_ext;
  logic [CW-1:0] last_col_idx;
  logic [CW-1:0] last_row_idx;
  logic          last_col;
  logic          last_row;
  logic          accept;

  assign width_ext  = CW'(cfg.frame_width);
  assign height_ext = CW'(cfg.frame_height);

  // Zero acts as one, oversize saturates at the counter range.
  always_comb begin
    priority if (width_ext == '0) last_col_idx = '0;
    else if (width_ext > DIM_TOP) last_col_idx = DIM_TOP - CW'(1);
    else last_col_idx = width_ext - CW'(1);

    priority if (height_ext == '0) last_row_idx = '0;
    else if (height_ext > DIM_TOP) last_row_idx = DIM_TOP - CW'(1);
    else last_row_idx = height_ext - CW'(1);
  end

  assign last_col = CW'(col) >= last_col_idx;
  assign last_row = CW'(row) >= last_row_idx;

  assign in_ready = !stage.valid || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        stage.valid <= 1'b1;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end else if (take) begin
        stage.valid <= 1'b0;
      end
    end
    if (accept) begin
      stage.rgb          <= in_pixel[r2y_pkg::RGB_W-1:0];
      stage.row          <= row;
      stage.col          <= col;
      stage.chroma_valid <= !col[0] && !row[0];
      stage.frame_end    <= last_col && last_row;
    end
  end

  // A frame-ending pixel sends both counters back to the origin.
  a_wrap_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    accept && last_col && last_row |=> col == '0 && row == '0)
    else $error("raster counters did not wrap at frame end");

  // An empty input register always takes a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage.valid |-> in_ready)
    else $error("input blocked while the input register is empty");

  // Hold the waiting pixel until the result register takes it.
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !take |=> stage.valid && $stable(stage.rgb) && $stable(stage.col)
      && $stable(stage.row))
    else $error("waiting pixel changed before it was taken");

endmodule

// File: rtl/r2y_csc.sv
`timescale 1ns / 1ps

module r2y_csc (
  input  logic [r2y_pkg::RGB_W-1:0]  rgb,
  output logic [r2y_pkg::BYTE_W-1:0] luma,
  output logic [r2y_pkg::BYTE_W-1:0] cb,
  output logic [r2y_pkg::BYTE_W-1:0] cr
);

  localparam logic [8:0] LUMA_FLOOR = 9'd16;
  localparam logic [8:0] BYTE_MAX   = 9'd255;

  logic [7:0]         r, g, b;
  logic signed [17:0] rs, gs, bs;
  logic [15:0]        y_sum;
  logic [8:0]         y_pre;
  logic signed [17:0] cb_sum;
  logic signed [17:0] cr_sum;

  // floor(sum / 256) + 128, clamped to a byte, via a biased shift.
  function automatic logic [7:0] chroma_byte(input logic signed [17:0] sum);
    logic signed [17:0] biased;
    biased = sum + 18'sd32768;
    if (biased < 0) return 8'd0;
    else if (biased[16]) return 8'hFF;
    else return biased[15:8];
  endfunction

  assign b = rgb[7:0];
  assign g = rgb[15:8];
  assign r = rgb[23:16];

  assign rs = $signed({10'd0, r});
  assign gs = $signed({10'd0, g});
  assign bs = $signed({10'd0, b});

  assign y_sum = 16'(r) * 16'd66 + 16'(g) * 16'd129 + 16'(b) * 16'd25 + 16'd128;
  assign y_pre = {1'b0, y_sum[15:8]} + LUMA_FLOOR;
  assign luma  = (y_pre > BYTE_MAX) ? 8'hFF : y_pre[7:0];

  assign cb_sum = 18'sd128 - 18'sd38 * rs - 18'sd74 * gs + 18'sd112 * bs;
  assign cr_sum = 18'sd128 + 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs;

  assign cb = chroma_byte(cb_sum);
  assign cr = chroma_byte(cr_sum);

endmodule

// File: rtl/r2y_addr.sv
`timescale 1ns / 1ps

module r2y_addr (
  input  r2y_pkg::cfg_t                        cfg,
  input  logic [r2y_pkg::MAX_DIM_BITS-1:0]     row,
  input  logic [r2y_pkg::MAX_DIM_BITS-1:0]     col,
  input  logic                                 chroma_valid,
  output logic [r2y_pkg::OFF_W-1:0]            luma_offset,
  output logic [r2y_pkg::OFF_W-1:0]            cb_offset,
  output logic [r2y_pkg::OFF_W-1:0]            cr_offset
);

  localparam int SW = r2y_pkg::SUM_W;
  localparam int OW = r2y_pkg::OFF_W;

  logic [r2y_pkg::MAX_DIM_BITS-1:0] half_row;
  logic [r2y_pkg::MAX_DIM_BITS-1:0] half_col;
  logic [r2y_pkg::MAX_DIM_BITS-1:0] cb_col;
  logic [SW-1:0] luma_full;
  logic [SW-1:0] cb_full;
  logic [SW-1:0] cr_full;
  logic [OW-1:0] cb_wrap;
  logic [OW-1:0] cr_wrap;

  assign half_row = row >> 1;
  assign half_col = col >> 1;
  // NV12 rows hold Cb/Cr pairs, so the column indexes bytes directly.
  assign cb_col   = (cfg.chroma_layout == r2y_pkg::LAYOUT_NV12) ? col : half_col;

  assign luma_full = SW'(row) * SW'(cfg.luma_stride) + SW'(col);
  assign cb_full   = SW'(half_row) * SW'(cfg.cb_stride) + SW'(cb_col);
  assign cr_full   = SW'(half_row) * SW'(cfg.cr_stride) + SW'(half_col);

  assign cb_wrap = cb_full[OW-1:0];
  assign cr_wrap = (cfg.chroma_layout == r2y_pkg::LAYOUT_NV12) ? cb_wrap + OW'(1)
                                                               : cr_full[OW-1:0];

  assign luma_offset = luma_full[OW-1:0];
  assign cb_offset   = chroma_valid ? cb_wrap : '0;
  assign cr_offset   = chroma_valid ? cr_wrap : '0;

endmodule

// File: rtl/rgb_to_yuv420_converter_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid / tready         tdata: BGRA pixel word
// m_axis    out        tvalid / tready         tdata, tuser chroma_valid, tlast frame_end
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock while m_axis is ready; input register, then result register.
// Color math and offset multiplies sit in one combinational pass between the two.
// Synchronous active-high rst clears the raster counters and valid flags and loads
// the register defaults.
// A stalled m_axis holds the result; the input register still takes one more pixel.
// cfg_ready is always high; write registers only while the block is idle.

module rgb_to_yuv420_converter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [r2y_pkg::PIXEL_W-1:0]         s_axis_tdata,   // pixel_word
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // luma, luma_offset, cb_value, cr_value, cb_offset, cr_offset, zero pad
  output logic [r2y_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tuser,   // chroma_valid
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [r2y_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int BW = r2y_pkg::BYTE_W;
  localparam int OW = r2y_pkg::OFF_W;

  r2y_pkg::cfg_t  cfg;
  r2y_pkg::scan_t stage;
  logic           take;
  logic [BW-1:0]  luma, cb, cr;
  logic [OW-1:0]  luma_offset, cb_offset, cr_offset;

  assign cfg_ready = 1'b1;
  assign take      = stage.valid && (!m_axis_tvalid || m_axis_tready);

  r2y_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  r2y_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_pixel (s_axis_tdata),
    .in_ready (s_axis_tready),
    .take     (take),
    .stage    (stage)
  );

  r2y_csc u_csc (
    .rgb  (stage.rgb),
    .luma (luma),
    .cb   (cb),
    .cr   (cr)
  );

  r2y_addr u_addr (
    .cfg          (cfg),
    .row          (stage.row),
    .col          (stage.col),
    .chroma_valid (stage.chroma_valid),
    .luma_offset  (luma_offset),
    .cb_offset    (cb_offset),
    .cr_offset    (cr_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= r2y_pkg::OUT_DATA_W'({
        cr_offset,
        cb_offset,
        stage.chroma_valid ? cr : 8'd0,
        stage.chroma_valid ? cb : 8'd0,
        luma_offset,
        luma
      });
      m_axis_tuser <= stage.chroma_valid;
      m_axis_tlast <= stage.frame_end;
    end
  end

  // Luma carries the studio-range floor, so it never falls below 16.
  a_luma_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[BW-1:0] >= 8'd16)
    else $error("luma below studio floor");

  // Without chroma the chroma bytes and offsets read as zero.
  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[r2y_pkg::RES_BITS-1:BW+OW] == '0)
    else $error("chroma fields set without chroma_valid");

  // NV12 places Cr right after Cb.
  a_nv12_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser && cfg.chroma_layout == r2y_pkg::LAYOUT_NV12 |->
    m_axis_tdata[3*BW+3*OW-1:3*BW+2*OW] == m_axis_tdata[3*BW+2*OW-1:3*BW+OW] + OW'(1))
    else $error("NV12 cr_offset is not cb_offset plus one");

endmodule
